[rtl/wmd_pkg.sv]
// wmd_pkg: shared constants, opcodes and controller/datapath bundles
// for the wildcard matcher. No dependencies.

package wmd_pkg;

   // Longest pattern the store holds
   localparam int MAX_PATTERN = 64;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int SYM_W       = 8;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

   // Request opcodes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEXT   = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   // Pattern symbols with special meaning
   localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
   localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;

   // Commands from controller to datapath
   typedef struct packed {
      logic              clear;      // empty the pattern
      logic              append;     // append req symbol to the pattern
      logic              txt_zero;   // text char against an empty pattern
      logic              txt_start;  // latch symbol, open a column walk
      logic              step;       // evaluate one pattern column
      logic              commit;     // last column: commit the new row
      logic              end_load;   // load the result register
      logic [ADDR_W-1:0] col;        // column under evaluation
      logic [ADDR_W-1:0] rd_addr;    // pattern store read address
   } wmd_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [LEN_W-1:0] len;
   } wmd_status_type;

endpackage

[rtl/wildcard_match_dp_top.sv]
// Glob matcher ('?' and '*') over a streamed text against a stored pattern.
// Clear, append and end of text need no column walk; a text character walks
// the L columns of a pattern of length L, one column per cycle, paced by
// the single read port of the pattern store. A result appears the cycle
// after its end-of-text transfer. Reset clears length, the empty-text and
// current rows and the started and overflow flags, not the pattern store.

module wildcard_match_dp_top
   import wmd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_opcode,
   input  logic [SYM_W-1:0] req_symbol,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_matched,
   output logic             rsp_pattern_too_long
);

   wmd_cmd_type    cmd;
   wmd_status_type status;

   // Sequencer
   wmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // Store, rows and result
   wmd_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_symbol           (req_symbol),
      .status               (status),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_too_long (rsp_pattern_too_long)
   );

endmodule

[rtl/wmd_ctrl.sv]
// wmd_ctrl: request decode, column-walk sequencer and result valid.
// Depends on wmd_pkg.

module wmd_ctrl
   import wmd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_opcode,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  wmd_status_type status,
   output wmd_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic              state_ff, state_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_accept;
   logic              last_col;

   // Hold off while walking columns, or when an end has nowhere to go
   assign req_stall  = (state_ff == ST_RUN) ||
                       ((req_opcode == OP_END) && rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign last_col   = ({1'b0, col_ff} == LEN_W'(status.len - LEN_W'(1)));

   // Next state and command decode
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  OP_CLEAR:  cmd.clear  = 1'b1;
                  OP_APPEND: cmd.append = 1'b1;
                  OP_TEXT: begin
                     if (status.len == '0) begin
                        cmd.txt_zero = 1'b1;
                     end else begin
                        cmd.txt_start = 1'b1;
                        col_in        = '0;
                        state_in      = ST_RUN;
                     end
                  end
                  OP_END: begin
                     cmd.end_load = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.step    = 1'b1;
            cmd.col     = col_ff;
            cmd.rd_addr = col_ff + ADDR_W'(1);
            col_in      = col_ff + ADDR_W'(1);
            if (last_col) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   // A column walk only runs over a non-empty pattern
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (status.len != '0))
      else $error("column walk with empty pattern");

   // The column index stays inside the pattern
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ({1'b0, col_ff} < LEN_W'(status.len)))
      else $error("column index beyond pattern length");

   // An accepted end of text always yields a result next cycle
   a_end_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == OP_END)) |=> rsp_valid_ff)
      else $error("end of text without result");

   // A started walk moves the sequencer into the run state
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.txt_start |=> (state_ff == ST_RUN))
      else $error("column walk did not start");
`endif

endmodule

[rtl/wmd_datapath.sv]
// wmd_datapath: pattern store, match rows, length/overflow and result regs.
// Depends on wmd_pkg; driven by wmd_ctrl commands.

module wmd_datapath
   import wmd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  wmd_cmd_type      cmd,
   input  logic [SYM_W-1:0] req_symbol,
   output wmd_status_type   status,
   output logic             rsp_matched,
   output logic             rsp_pattern_too_long
);

   logic [SYM_W-1:0]       mem [MAX_PATTERN];
   logic [SYM_W-1:0]       pdata_ff;

   logic [LEN_W-1:0]       len_ff, len_in;
   logic [MAX_PATTERN-1:0] empty_row_ff, empty_row_in;
   logic [MAX_PATTERN-1:0] cur_row_ff, cur_row_in;
   logic [MAX_PATTERN-1:0] next_row_ff, next_row_in;
   logic                   started_ff, started_in;
   logic                   ovf_ff, ovf_in;
   logic                   left_ff, left_in;
   logic                   old0_ff, old0_in;
   logic [SYM_W-1:0]       sym_ff, sym_in;
   logic                   matched_ff, matched_in;
   logic                   too_long_ff, too_long_in;

   logic [ADDR_W-1:0]      len_idx;
   logic [ADDR_W-1:0]      len_prev;
   logic [ADDR_W-1:0]      col_prev;
   logic                   has_room;
   logic                   empty_prev;
   logic                   pat_star;
   logic                   pat_hit;
   logic                   cur_at;
   logic                   cur_prev;
   logic                   step_bit;
   logic [MAX_PATTERN-1:0] next_upd;

   assign status.len           = len_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_too_long = too_long_ff;

   assign len_idx  = len_ff[ADDR_W-1:0];
   assign len_prev = len_idx - ADDR_W'(1);
   assign col_prev = cmd.col - ADDR_W'(1);
   assign has_room = (len_ff < MAX_LEN);

   // Empty-text bit of the prefix one shorter than the new one
   assign empty_prev = (len_ff == '0) ? 1'b1 : empty_row_ff[len_prev];

   // One column of the row update
   always_comb begin
      pat_star = (pdata_ff == SYM_STAR);
      pat_hit  = (pdata_ff == SYM_ANY) || (pdata_ff == sym_ff);
      cur_at   = cur_row_ff[cmd.col];
      cur_prev = (cmd.col == '0) ? old0_ff : cur_row_ff[col_prev];
      step_bit = pat_star ? (left_ff | cur_at) : (pat_hit & cur_prev);
      next_upd = next_row_ff;
      next_upd[cmd.col] = step_bit;
   end

   // Next values
   always_comb begin
      len_in       = len_ff;
      empty_row_in = empty_row_ff;
      cur_row_in   = cur_row_ff;
      next_row_in  = next_row_ff;
      started_in   = started_ff;
      ovf_in       = ovf_ff;
      left_in      = left_ff;
      old0_in      = old0_ff;
      sym_in       = sym_ff;
      matched_in   = matched_ff;
      too_long_in  = too_long_ff;

      if (cmd.clear) begin
         len_in       = '0;
         empty_row_in = '0;
         ovf_in       = 1'b0;
         cur_row_in   = '0;
         started_in   = 1'b0;
      end

      if (cmd.append) begin
         if (has_room) begin
            if ((req_symbol == SYM_STAR) && empty_prev) begin
               empty_row_in[len_idx] = 1'b1;
            end
            len_in = len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         cur_row_in = empty_row_in;
         started_in = 1'b0;
      end

      if (cmd.txt_zero) begin
         cur_row_in = '0;
         started_in = 1'b1;
      end

      if (cmd.txt_start) begin
         next_row_in = '0;
         left_in     = 1'b0;
         old0_in     = !started_ff;
         sym_in      = req_symbol;
      end

      if (cmd.step) begin
         next_row_in = next_upd;
         left_in     = step_bit;
      end

      if (cmd.commit) begin
         cur_row_in = next_upd;
         started_in = 1'b1;
      end

      if (cmd.end_load) begin
         if (ovf_ff) begin
            matched_in = 1'b0;
         end else if (len_ff == '0) begin
            matched_in = !started_ff;
         end else begin
            matched_in = cur_row_ff[len_prev];
         end
         too_long_in = ovf_ff;
         cur_row_in  = empty_row_ff;
         started_in  = 1'b0;
      end
   end

   // Pattern store: one write on append while there is room, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.append && has_room) begin
         mem[len_idx] <= req_symbol;
      end
      pdata_ff <= mem[cmd.rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         empty_row_ff <= '0;
         cur_row_ff   <= '0;
         started_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         len_ff       <= len_in;
         empty_row_ff <= empty_row_in;
         cur_row_ff   <= cur_row_in;
         started_ff   <= started_in;
         ovf_ff       <= ovf_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      next_row_ff <= next_row_in;
      left_ff     <= left_in;
      old0_ff     <= old0_in;
      sym_ff      <= sym_in;
      matched_ff  <= matched_in;
      too_long_ff <= too_long_in;
   end

endmodule

[bench/wildcard_match_dp_top_test.sv]
// Self-checking bench for wildcard_match_dp_top: streams glob commands with random
// gaps and stalls, and checks each end-of-text verdict against a behavioral predictor.
// Depends on wmd_pkg and the wildcard_match_dp_top RTL.

module wildcard_match_dp_top_test
   import wmd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [SYM_W-1:0] symbol;
   } glob_cmd_type;

   typedef struct packed {
      logic matched;
      logic too_long;
   } verdict_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_opcode = OP_CLEAR;
   logic [SYM_W-1:0] req_symbol = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_matched;
   logic             rsp_pattern_too_long;

   wildcard_match_dp_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_symbol           (req_symbol),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_too_long (rsp_pattern_too_long)
   );

   always #5ns clock = ~clock;

   glob_cmd_type glob_commands[$];
   verdict_type  predicted_verdicts[$];
   bit           failed = 1'b0;

   // Predictor state: pattern, rows of prefix match bits, flags
   logic [SYM_W-1:0]       pat_chars [MAX_PATTERN];
   int unsigned            pat_len = 0;
   logic [MAX_PATTERN-1:0] empty_row = '0;
   logic [MAX_PATTERN-1:0] cur_row = '0;
   bit                     text_begun = 1'b0;
   bit                     overflow = 1'b0;

   // Match bit of prefix length col; the empty prefix is col0
   function automatic bit prefix_hit(logic [MAX_PATTERN-1:0] row, int col, bit col0);
      return (col == 0) ? col0 : row[ADDR_W'(col-1)];
   endfunction

   // Advance the predictor by one accepted command; queue a verdict on end of text
   function automatic void track_glob_command(logic [1:0] op, logic [SYM_W-1:0] sym);
      logic [MAX_PATTERN-1:0] nxt;
      bit left, hit, old0;
      verdict_type v;
      nxt = '0;
      left = 1'b0;
      old0 = !text_begun;
      case (op)
         OP_CLEAR: begin
            pat_len = 0;
            empty_row = '0;
            overflow = 1'b0;
            cur_row = empty_row;
            text_begun = 1'b0;
         end
         OP_APPEND: begin
            if (pat_len < MAX_PATTERN) begin
               pat_chars[ADDR_W'(pat_len)] = sym;
               if (sym == SYM_STAR && prefix_hit(empty_row, pat_len, 1'b1))
                  empty_row[ADDR_W'(pat_len)] = 1'b1;
               pat_len++;
            end else begin
               overflow = 1'b1;
            end
            cur_row = empty_row;
            text_begun = 1'b0;
         end
         OP_TEXT: begin
            // left carries the star ripple along the row
            for (int j = 1; j <= pat_len; j++) begin
               if (pat_chars[ADDR_W'(j-1)] == SYM_STAR)
                  hit = left || prefix_hit(cur_row, j, old0);
               else if (pat_chars[ADDR_W'(j-1)] == SYM_ANY ||
                        pat_chars[ADDR_W'(j-1)] == sym)
                  hit = prefix_hit(cur_row, j - 1, old0);
               else
                  hit = 1'b0;
               nxt[ADDR_W'(j-1)] = hit;
               left = hit;
            end
            cur_row = nxt;
            text_begun = 1'b1;
         end
         default: begin
            if (overflow)
               v.matched = 1'b0;
            else if (pat_len == 0)
               v.matched = !text_begun;
            else
               v.matched = cur_row[ADDR_W'(pat_len-1)];
            v.too_long = overflow;
            predicted_verdicts.push_back(v);
            cur_row = empty_row;
            text_begun = 1'b0;
         end
      endcase
   endfunction

   // Driver: holds each command until its transfer, then waits its gap
   int  req_gap = 0;
   bit  req_calm = 1'b0;
   glob_cmd_type next_cmd;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (req_valid && !req_stall) begin
         track_glob_command(req_opcode, req_symbol);
         if ($urandom_range(0, 39) == 0)
            req_calm = !req_calm;
         req_gap = req_calm ? 0 : $urandom_range(0, 13);
         if (req_gap == 0 && glob_commands.size() != 0) begin
            next_cmd = glob_commands.pop_front();
            req_opcode <= next_cmd.opcode;
            req_symbol <= next_cmd.symbol;
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (req_gap != 0) begin
            req_gap--;
         end else if (glob_commands.size() != 0) begin
            next_cmd = glob_commands.pop_front();
            req_valid <= 1'b1;
            req_opcode <= next_cmd.opcode;
            req_symbol <= next_cmd.symbol;
         end
      end
   end

   // Monitor: checks each result transfer, then stalls for a random stretch
   int  rsp_hold = 0;
   bit  rsp_calm = 1'b0;
   verdict_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_verdicts.size() == 0) begin
               $display("%0t unexpected result: matched=%0b too_long=%0b",
                        $time, rsp_matched, rsp_pattern_too_long);
               failed = 1'b1;
            end else begin
               want = predicted_verdicts.pop_front();
               if (rsp_matched !== want.matched) begin
                  $display("%0t matched: expected %0b, got %0b",
                           $time, want.matched, rsp_matched);
                  failed = 1'b1;
               end
               if (rsp_pattern_too_long !== want.too_long) begin
                  $display("%0t pattern_too_long: expected %0b, got %0b",
                           $time, want.too_long, rsp_pattern_too_long);
                  failed = 1'b1;
               end
            end
            if ($urandom_range(0, 29) == 0)
               rsp_calm = !rsp_calm;
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 13);
         end
         rsp_stall <= (rsp_hold != 0);
         if (rsp_hold != 0)
            rsp_hold--;
      end
   end

   // Stimulus generation
   int unsigned      random_count = 0;
   logic [SYM_W-1:0] gen_pattern [$];

   task automatic send(logic [1:0] op, logic [SYM_W-1:0] sym);
      glob_cmd_type c;
      c.opcode = op;
      c.symbol = sym;
      glob_commands.push_back(c);
      random_count++;
   endtask

   // Small alphabet so that literals collide often, plus any byte
   function automatic logic [SYM_W-1:0] pick_char(int star_weight);
      int r;
      r = $urandom_range(0, 9 + star_weight);
      if (r <= 2) return 8'h61;
      if (r <= 4) return 8'h62;
      if (r == 5) return 8'h63;
      if (r == 6) return SYM_ANY;
      if (r <= 7 + star_weight) return SYM_STAR;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic append_char(logic [SYM_W-1:0] sym);
      send(OP_APPEND, sym);
      gen_pattern.push_back(sym);
   endtask

   // One text, built to match the stored pattern or drawn at random
   task automatic send_text(bit aim_match);
      int n;
      if (aim_match) begin
         for (int k = 0; k < gen_pattern.size() && k < MAX_PATTERN; k++) begin
            if (gen_pattern[k] == SYM_STAR) begin
               n = $urandom_range(0, 3);
               repeat (n) send(OP_TEXT, pick_char(0));
            end else if (gen_pattern[k] == SYM_ANY) begin
               send(OP_TEXT, pick_char(1));
            end else begin
               send(OP_TEXT, gen_pattern[k]);
            end
         end
      end else begin
         n = $urandom_range(0, 8);
         repeat (n) send(OP_TEXT, pick_char(1));
      end
      // a broken text: the pattern grows mid-stream and the text restarts
      if ($urandom_range(0, 9) == 0) begin
         append_char(pick_char(2));
         send(OP_TEXT, pick_char(1));
      end
      send(OP_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic glob_session(int len);
      send(OP_CLEAR, 8'($urandom_range(0, 255)));
      gen_pattern.delete();
      repeat (len) append_char(pick_char(3));
      repeat ($urandom_range(1, 4)) send_text(1'($urandom_range(0, 1)));
   endtask

   initial begin
      // Directed: empty pattern, extremes of the symbol, star and any, star in text
      send(OP_END, 8'hFF);
      send(OP_TEXT, 8'h61);
      send(OP_END, 8'h00);
      send(OP_APPEND, SYM_STAR);
      send(OP_END, 8'h00);
      send(OP_TEXT, SYM_STAR);
      send(OP_TEXT, 8'hFF);
      send(OP_END, 8'h00);
      send(OP_CLEAR, 8'hFF);
      send(OP_APPEND, SYM_ANY);
      send(OP_APPEND, 8'h00);
      send(OP_TEXT, 8'h7E);
      send(OP_TEXT, 8'h00);
      send(OP_END, 8'h00);
      send(OP_TEXT, 8'h00);
      send(OP_END, 8'h00);
      send(OP_APPEND, 8'h61);
      send(OP_END, 8'h00);
      send(OP_CLEAR, 8'h00);
      send(OP_APPEND, 8'hFF);
      send(OP_TEXT, SYM_STAR);
      send(OP_END, 8'h00);
      send(OP_TEXT, 8'hFF);
      send(OP_END, 8'h00);
      gen_pattern.delete();
      random_count = 0;

      // Random: mostly well-formed sessions, some long or overflowing, some noise
      while (random_count < 1000) begin
         case ($urandom_range(0, 19))
            0, 1: repeat ($urandom_range(1, 6))
                     send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            2:    glob_session($urandom_range(MAX_PATTERN - 3, MAX_PATTERN + 3));
            default: glob_session($urandom_range(0, 8));
         endcase
      end
   end

   // Run control
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (glob_commands.size() != 0 || req_valid || predicted_verdicts.size() != 0)
         @(posedge clock);
      repeat (2 * MAX_PATTERN + 20) @(posedge clock);
      if (!failed)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
